>>> rtl/rc5_pkg.sv
package rc5_pkg;

    // Word and block geometry of the cipher.
    localparam int WORD_W  = 16;
    localparam int BLOCK_W = 2 * WORD_W;
    localparam int KEY_W   = 64;
    localparam int KEY_WORDS = KEY_W / WORD_W;
    localparam int ROT_W   = 4;

    // Default number of rounds.
    localparam int ROUNDS_DEF = 3;

    // Magic constants of the key schedule.
    localparam logic [WORD_W-1:0] MAGIC_P = 16'hb7e5;
    localparam logic [WORD_W-1:0] MAGIC_Q = 16'h9e37;

    // Rotate amount of the subkey half of a key schedule step.
    localparam logic [ROT_W-1:0] SCHED_ROT = 4'd3;

    // Operation codes carried in tuser.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Configuration register map.
    localparam int  CFG_ADDR_W       = 4;
    localparam logic CIPHER_KEY_INDEX = 1'b0;

    typedef logic [WORD_W-1:0] t_word;

    // Key expansion sequencer states.
    typedef enum logic [1:0] {
        EXP_LOAD,
        EXP_MIX,
        EXP_DONE
    } t_exp_state;

    // Rotate a word left by the low bits of an amount.
    function automatic t_word rotl16(t_word x, logic [ROT_W-1:0] amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << amt;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    // Rotate a word right by the low bits of an amount.
    function automatic t_word rotr16(t_word x, logic [ROT_W-1:0] amt);
        logic [ROT_W-1:0] left_amt;
        left_amt = ROT_W'(~amt + 1'b1);
        return rotl16(x, left_amt);
    endfunction

    // Initial subkey table entry k before mixing.
    function automatic t_word subkey_init(int k);
        return WORD_W'(int'(MAGIC_P) + k * int'(MAGIC_Q));
    endfunction

endpackage

>>> rtl/rc5_16bit_block_cipher_unit.sv
// An accepted block passes through the input register and then the result register.
// One block per cycle unless the output stalls; the three rounds are unrolled between them.
// A key write, and reset, start a key expansion: the subkey table is loaded, then mixed,
// one mixing step per cycle through the subkey table; no input is taken until it ends.
// Reset is synchronous and active low; it clears the key to zero and expands that key.
module rc5_16bit_block_cipher_unit
    import rc5_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BLOCK_W-1:0]    s_axis_tdata,   // [31:0] data_block
    input  logic                  s_axis_tuser,   // [0] operation
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BLOCK_W-1:0]    m_axis_tdata,   // [31:0] result_block
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [KEY_W-1:0]      pwdata,
    output logic [KEY_W-1:0]      prdata,
    output logic                  pready
);

    localparam int TW     = 2 * (ROUNDS + 1);
    localparam int MIX    = 3 * TW;
    localparam int IW     = $clog2(TW);
    localparam int CW     = $clog2(MIX);
    localparam int JW     = $clog2(KEY_WORDS);

    // Configuration registers.
    logic [KEY_W-1:0] r_cipher_key;
    logic             w_cfg_hit;
    logic             w_cfg_wr;

    // Key expansion state.
    t_exp_state       r_exp_state;
    t_exp_state       n_exp_state;
    logic [CW-1:0]    r_mix_cnt;
    logic [IW-1:0]    r_mix_i;
    logic [JW-1:0]    r_mix_j;
    t_word            r_mix_a;
    t_word            r_mix_b;
    t_word            r_lkey [KEY_WORDS];
    t_word            r_skey [TW];
    t_word            w_step_a;
    t_word            w_step_b;
    t_word            w_sum_a;
    t_word            w_sum_b;
    t_word            w_amt_b;

    // Datapath registers.
    logic             r_in_valid;
    logic             r_in_op;
    logic [BLOCK_W-1:0] r_in_data;
    logic             r_out_valid;
    logic [BLOCK_W-1:0] r_out_data;
    logic [BLOCK_W-1:0] w_result;
    logic             w_out_free;
    logic             w_in_free;
    logic             w_in_take;

    // APB decode; pready is always high.
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[3] == CIPHER_KEY_INDEX) && (paddr[2:0] == 3'd0);
    assign w_cfg_wr  = psel && penable && pwrite && pready && (paddr[3] == CIPHER_KEY_INDEX);
    assign prdata    = w_cfg_hit ? r_cipher_key : '0;

    // Key register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (w_cfg_wr) begin
            r_cipher_key <= pwdata;
        end
    end

    // Expansion sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_state <= EXP_LOAD;
        end else begin
            r_exp_state <= n_exp_state;
        end
    end

    // Next state: a key write restarts the expansion from the loaded table.
    always_comb begin
        n_exp_state = r_exp_state;
        case (r_exp_state)
            EXP_LOAD: begin
                n_exp_state = EXP_MIX;
            end
            EXP_MIX: begin
                if (r_mix_cnt == CW'(MIX - 1)) begin
                    n_exp_state = EXP_DONE;
                end
            end
            EXP_DONE: begin
                n_exp_state = EXP_DONE;
            end
            default: begin
                n_exp_state = EXP_LOAD;
            end
        endcase
        if (w_cfg_wr) begin
            n_exp_state = EXP_LOAD;
        end
    end

    // One mixing step of the key schedule.
    always_comb begin
        w_sum_a  = r_skey[r_mix_i] + r_mix_a + r_mix_b;
        w_step_a = rotl16(w_sum_a, SCHED_ROT);
        w_sum_b  = r_lkey[r_mix_j] + w_step_a + r_mix_b;
        w_amt_b  = w_step_a + r_mix_b;
        w_step_b = rotl16(w_sum_b, w_amt_b[ROT_W-1:0]);
    end

    // Mixing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_cnt <= '0;
            r_mix_i   <= '0;
            r_mix_j   <= '0;
        end else if (r_exp_state == EXP_LOAD) begin
            r_mix_cnt <= '0;
            r_mix_i   <= '0;
            r_mix_j   <= '0;
        end else if (r_exp_state == EXP_MIX) begin
            r_mix_cnt <= r_mix_cnt + 1'b1;
            r_mix_i   <= (r_mix_i == IW'(TW - 1)) ? '0 : r_mix_i + 1'b1;
            r_mix_j   <= r_mix_j + 1'b1;
        end
    end

    // Subkey table and mixing words.
    always_ff @(posedge i_clk) begin
        if (r_exp_state == EXP_LOAD) begin
            r_mix_a <= '0;
            r_mix_b <= '0;
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_lkey[k] <= r_cipher_key[k*WORD_W +: WORD_W];
            end
            for (int k = 0; k < TW; k++) begin
                r_skey[k] <= subkey_init(k);
            end
        end else if (r_exp_state == EXP_MIX) begin
            r_mix_a          <= w_step_a;
            r_mix_b          <= w_step_b;
            r_skey[r_mix_i]  <= w_step_a;
            r_lkey[r_mix_j]  <= w_step_b;
        end
    end

    // Pipeline flow control.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_free     = !r_in_valid || w_out_free;
    assign s_axis_tready = w_in_free && (r_exp_state == EXP_DONE);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= w_in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    // Unrolled rounds for both directions.
    always_comb begin
        t_word ea;
        t_word eb;
        t_word da;
        t_word db;
        ea = r_in_data[WORD_W-1:0] + r_skey[0];
        eb = r_in_data[BLOCK_W-1:WORD_W] + r_skey[1];
        for (int r = 1; r <= ROUNDS; r++) begin
            ea = rotl16(ea ^ eb, eb[ROT_W-1:0]) + r_skey[2*r];
            eb = rotl16(eb ^ ea, ea[ROT_W-1:0]) + r_skey[2*r+1];
        end
        da = r_in_data[WORD_W-1:0];
        db = r_in_data[BLOCK_W-1:WORD_W];
        for (int r = ROUNDS; r >= 1; r--) begin
            db = rotr16(db - r_skey[2*r+1], da[ROT_W-1:0]) ^ da;
            da = rotr16(da - r_skey[2*r], db[ROT_W-1:0]) ^ db;
        end
        db = db - r_skey[1];
        da = da - r_skey[0];
        w_result = (r_in_op == OP_DECRYPT) ? {db, da} : {eb, ea};
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A key write always restarts the expansion.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_exp_state == EXP_LOAD))
        else $error("key write did not restart the expansion");

    // The expansion ends after its last mixing step unless a new key arrives.
    a_mix_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_state == EXP_MIX) && (r_mix_cnt == CW'(MIX - 1)) && !w_cfg_wr
        |=> (r_exp_state == EXP_DONE))
        else $error("expansion did not finish after its last step");

    // No block is taken while the subkey table is being built.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |-> (r_exp_state == EXP_DONE) && (r_mix_cnt == CW'(MIX)))
        else $error("block accepted during key expansion");

    // A staged item moves to the result register when it is free.
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_out_free |=> r_out_valid)
        else $error("staged item lost between pipeline registers");

    // A stalled result is not overwritten by the item behind it.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result was replaced");
`endif

endmodule

>>> tb/rc5_cipher_checker.sv
`timescale 1ns / 100ps

module rc5_cipher_checker
    import rc5_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream as seen by the block.
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [BLOCK_W-1:0]    i_in_block,
    input  logic                  i_in_op,
    // Output stream as seen by the block.
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [BLOCK_W-1:0]    i_out_block,
    // Configuration port.
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [KEY_W-1:0]      i_pwdata,
    input  logic [KEY_W-1:0]      i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int TABLE_WORDS = 2 * (ROUNDS_DEF + 1);
    localparam int MIX_STEPS   = 3 * TABLE_WORDS;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_ADDR_W-1:0] KEY_ADDR = CFG_ADDR_W'(8 * int'(CIPHER_KEY_INDEX));

    // Model copy of the key register and the expanded subkey table.
    logic [KEY_W-1:0]  key_shadow;
    logic [WORD_W-1:0] subkeys [TABLE_WORDS];

    // Result blocks still owed by the block, oldest first.
    logic [BLOCK_W-1:0] cipher_results_due [$];

    int fails = 0;
    int due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    // Left rotate of a word; an amount of zero leaves it as it is.
    function automatic logic [WORD_W-1:0] rol_word(logic [WORD_W-1:0] x, logic [3:0] amt);
        if (amt == 4'd0)
            return x;
        return (x << amt) | (x >> (5'd16 - amt));
    endfunction

    function automatic logic [WORD_W-1:0] ror_word(logic [WORD_W-1:0] x, logic [3:0] amt);
        logic [3:0] left_amt;
        left_amt = 4'd0 - amt;
        return rol_word(x, left_amt);
    endfunction

    // Key schedule: seed the table from the magic constants, then mix in the key words.
    function automatic void expand_subkeys(logic [KEY_W-1:0] key);
        logic [WORD_W-1:0] kw [4];
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] sum;
        int i;
        int j;
        int k;
        for (k = 0; k < 4; k++)
            kw[k] = key[16*k +: 16];
        subkeys[0] = MAGIC_P;
        for (k = 1; k < TABLE_WORDS; k++)
            subkeys[k] = subkeys[k-1] + MAGIC_Q;
        a = '0;
        b = '0;
        i = 0;
        j = 0;
        for (k = 0; k < MIX_STEPS; k++) begin
            sum = subkeys[i] + a + b;
            a = rol_word(sum, SCHED_ROT);
            subkeys[i] = a;
            sum = a + b;
            b = rol_word(kw[j] + sum, sum[3:0]);
            kw[j] = b;
            i = (i + 1) % TABLE_WORDS;
            j = (j + 1) % 4;
        end
    endfunction

    // Encrypt or decrypt one block with the current subkey table.
    function automatic logic [BLOCK_W-1:0] cipher_block(logic op, logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        int r;
        a = blk[WORD_W-1:0];
        b = blk[BLOCK_W-1:WORD_W];
        if (op == OP_ENCRYPT) begin
            a = a + subkeys[0];
            b = b + subkeys[1];
            for (r = 1; r <= ROUNDS_DEF; r++) begin
                a = rol_word(a ^ b, b[3:0]) + subkeys[2*r];
                b = rol_word(b ^ a, a[3:0]) + subkeys[2*r+1];
            end
        end else begin
            for (r = ROUNDS_DEF; r >= 1; r--) begin
                b = ror_word(b - subkeys[2*r+1], a[3:0]) ^ a;
                a = ror_word(a - subkeys[2*r], b[3:0]) ^ b;
            end
            b = b - subkeys[1];
            a = a - subkeys[0];
        end
        return {b, a};
    endfunction

    function automatic void note_failure(string msg);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Watch every channel at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_shadow = '0;
            expand_subkeys('0);
            cipher_results_due.delete();
        end else begin
            // Configuration transactions: writes re-key the model, reads are checked.
            if (i_psel && i_penable && i_pready && i_paddr == KEY_ADDR) begin
                if (i_pwrite) begin
                    key_shadow = i_pwdata;
                    expand_subkeys(i_pwdata);
                end else if (i_prdata !== key_shadow) begin
                    note_failure($sformatf("key read expected %h, got %h",
                                           key_shadow, i_prdata));
                end
            end

            // Each accepted input transaction owes exactly one result.
            if (i_in_valid && i_in_ready)
                cipher_results_due.push_back(cipher_block(i_in_op, i_in_block));

            // Each accepted output transaction is matched against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (cipher_results_due.size() == 0) begin
                    note_failure($sformatf("unexpected result block %h", i_out_block));
                end else begin
                    if (i_out_block !== cipher_results_due[0])
                        note_failure($sformatf("result_block expected %h, got %h",
                                               cipher_results_due[0], i_out_block));
                    void'(cipher_results_due.pop_front());
                end
            end
        end
        due_count = cipher_results_due.size();
    end

endmodule

>>> tb/tb_rc5_16bit_block_cipher_unit.sv
`timescale 1ns / 100ps

module tb_rc5_16bit_block_cipher_unit;
    import rc5_pkg::*;

    localparam int PHASE_ITEMS   = 110;
    localparam int HOLD_CYCLES   = 150;
    localparam int UNMAPPED_INDEX = 1;
    localparam logic [CFG_ADDR_W-1:0] KEY_ADDR   = CFG_ADDR_W'(8 * int'(CIPHER_KEY_INDEX));
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(8 * UNMAPPED_INDEX);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BLOCK_W-1:0]    s_axis_tdata;   // [31:0] data_block
    logic                  s_axis_tuser;   // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BLOCK_W-1:0]    m_axis_tdata;   // [31:0] result_block
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [KEY_W-1:0]      pwdata;
    logic [KEY_W-1:0]      prdata;
    logic                  pready;

    int fail_count;
    int blocks_due;

    // Percent chances of a sender gap and of a receiver stall in a cycle.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Long receiver hold-offs asked for and already started.
    int holds_asked = 0;
    int holds_started = 0;
    int hold_left = 0;

    rc5_16bit_block_cipher_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rc5_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_block   (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_block  (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (blocks_due)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: held off in reset, random stalls, plus a long hold-off counted here
    // when one is asked for.
    always @(negedge i_clk) begin
        if (holds_started < holds_asked) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one block, with random gaps first, and return once it is accepted.
    task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One configuration transaction: a setup phase, then access until pready.
    task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [KEY_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        wait (blocks_due == 0);
        @(negedge i_clk);
    endtask

    task automatic rekey(input logic [KEY_W-1:0] key);
        cfg_access(1'b1, KEY_ADDR, key);
        cfg_access(1'b0, KEY_ADDR, '0);
    endtask

    function automatic logic pick_op();
        return $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
    endfunction

    // Stimulus and verdict.
    initial begin
        logic [KEY_W-1:0] key;
        int phase;
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENCRYPT;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        cfg_access(1'b0, KEY_ADDR, '0);

        // Directed blocks under the reset key: extremes, half words, alternating bits and single bits.
        send_block(OP_ENCRYPT, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hffff_ffff);
        send_block(OP_DECRYPT, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'hffff_ffff);
        send_block(OP_ENCRYPT, 32'h0000_ffff);
        send_block(OP_ENCRYPT, 32'hffff_0000);
        send_block(OP_DECRYPT, 32'h0000_ffff);
        send_block(OP_DECRYPT, 32'hffff_0000);
        send_block(OP_ENCRYPT, 32'haaaa_5555);
        send_block(OP_DECRYPT, 32'h5555_aaaa);
        send_block(OP_ENCRYPT, 32'h0000_0001);
        send_block(OP_ENCRYPT, 32'h8000_0000);
        drain();

        // All-ones key.
        rekey('1);
        send_block(OP_ENCRYPT, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hffff_ffff);
        send_block(OP_DECRYPT, 32'hffff_ffff);
        send_block(OP_ENCRYPT, 32'h1234_5678);
        send_block(OP_DECRYPT, 32'h9abc_def0);
        drain();

        // A write outside the register map must leave the key untouched.
        cfg_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
        cfg_access(1'b0, KEY_ADDR, '0);

        // Random phases with different idling, the last one with a long receiver hold-off.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  key = {$urandom, $urandom};
                end
                1: begin
                    send_idle_pct = 81; recv_stall_pct = 0;  key = '0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 81; key = {$urandom, $urandom};
                end
                3: begin
                    send_idle_pct = 35; recv_stall_pct = 35; key = 64'h0123_4567_89ab_cdef;
                end
                default: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  key = {$urandom, $urandom};
                end
            endcase
            rekey(key);
            if (phase == 4)
                holds_asked++;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_block(pick_op(), $urandom);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
